FILE: rtl/grid_min_entry_budget_dp_core_macros.svh
// assertion macros for the grid minimum entry budget core
`ifndef GRID_MIN_ENTRY_BUDGET_DP_CORE_MACROS_SVH
`define GRID_MIN_ENTRY_BUDGET_DP_CORE_MACROS_SVH

`ifndef SYNTH
`define GMEB_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GMEB_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GMEB_ASSERT_SAME(name, clk, rstn, ante, cons)
`define GMEB_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/gmeb_pkg.sv
// shared types, constants and helpers of the grid minimum entry budget core
`timescale 1ns / 1ps

package gmeb_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CFG_W    = 11;
  localparam int VAL_W    = 16;
  localparam int BUDGET_W = 31;
  localparam int CFG_IDX_W = 1;

  localparam logic [BUDGET_W-1:0] BUDGET_MAX = {BUDGET_W{1'b1}};
  localparam logic [BUDGET_W-1:0] BUDGET_ONE = BUDGET_W'(1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b1;

  // position info of one cell, travels with it down the pipe
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             first_row;
    logic             first_col;
    logic             last_col;
    logic             last_row;
  } cell_pos_t;

  // zero acts as one, anything above the cap acts as the cap
  function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > cap) begin
      r = cap;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/gmeb_row_mem.sv
// row budget memory: one write port, one registered read port
`timescale 1ns / 1ps

module gmeb_row_mem (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [gmeb_pkg::COL_W-1:0]    rd_addr_i,
  output logic [gmeb_pkg::BUDGET_W-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [gmeb_pkg::COL_W-1:0]    wr_addr_i,
  input  logic [gmeb_pkg::BUDGET_W-1:0] wr_data_i
);
  import gmeb_pkg::*;

  logic [BUDGET_W-1:0] mem_q [MAX_COLS];
  logic [BUDGET_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/gmeb_pos_ctrl.sv
// grid size registers and row / column position counters
`timescale 1ns / 1ps

module gmeb_pos_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gmeb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gmeb_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           advance_i,
  output gmeb_pkg::cell_pos_t            pos_o
);
  import gmeb_pkg::*;

  logic [CFG_W-1:0] cols_q, rows_q;
  logic [CFG_W-1:0] cols_eff, rows_eff;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             last_col, last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_W'(1);
      rows_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_COLS: cols_q <= cfg_wdata_i;
        CFG_GRID_ROWS: rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cols_eff = eff_size(cols_q, CFG_W'(MAX_COLS));
  assign rows_eff = eff_size(rows_q, CFG_W'(MAX_ROWS));

  assign last_col = (CFG_W'(col_q) + CFG_W'(1)) >= cols_eff;
  assign last_row = (CFG_W'(row_q) + CFG_W'(1)) >= rows_eff;

  always_comb begin
    col_d = col_q + COL_W'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col       = col_q;
  assign pos_o.first_row = (row_q == '0);
  assign pos_o.first_col = (col_q == '0);
  assign pos_o.last_col  = last_col;
  assign pos_o.last_row  = last_row;

endmodule

FILE: rtl/gmeb_cell_calc.sv
// successor select, subtract and clamp for one cell
`timescale 1ns / 1ps

module gmeb_cell_calc (
  input  gmeb_pkg::cell_pos_t           pos_i,
  input  logic [gmeb_pkg::BUDGET_W-1:0] below_i,
  input  logic [gmeb_pkg::BUDGET_W-1:0] right_i,
  input  logic [gmeb_pkg::VAL_W-1:0]    cell_value_i,
  output logic [gmeb_pkg::BUDGET_W-1:0] need_o,
  output logic                          clip_o
);
  import gmeb_pkg::*;

  localparam int DIFF_W = BUDGET_W + 2;

  logic [BUDGET_W-1:0] succ;
  logic [DIFF_W-1:0]   diff;

  always_comb begin
    if (pos_i.first_row && pos_i.first_col) begin
      succ = BUDGET_ONE;
    end else if (pos_i.first_row) begin
      succ = right_i;
    end else if (pos_i.first_col) begin
      succ = below_i;
    end else begin
      succ = (below_i < right_i) ? below_i : right_i;
    end
  end

  // top bit is the sign, the range never reaches it from above
  assign diff = {2'b00, succ}
              - {{(DIFF_W - VAL_W){cell_value_i[VAL_W-1]}}, cell_value_i};

  always_comb begin
    clip_o = 1'b0;
    if (diff[DIFF_W-1] || diff == '0) begin
      need_o = BUDGET_ONE;
    end else if (diff[DIFF_W-2]) begin
      need_o = BUDGET_MAX;
      clip_o = 1'b1;
    end else begin
      need_o = diff[BUDGET_W-1:0];
    end
  end

endmodule

FILE: rtl/grid_min_entry_budget_dp_core.sv
// top level of the grid minimum entry budget core
// a taken cell is held in the compute stage, then its result is registered in the output register
// throughput: one cell per cycle while the output is not stalled, set by the single row memory read-modify-write
// the read of one cell overlaps the write-back of the one before it
// reset: sizes to one by one, positions to bottom-right, right budget to one
// the row memory is not cleared, each row is written before the next one reads it
`timescale 1ns / 1ps

module grid_min_entry_budget_dp_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [gmeb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gmeb_pkg::CFG_W-1:0]     cfg_wdata_i,
  // cell input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [gmeb_pkg::VAL_W-1:0]     cell_value_i,
  // result output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gmeb_pkg::BUDGET_W-1:0]  need_budget_o,
  output logic                           is_answer_o,
  output logic                           saturated_o
);
  import gmeb_pkg::*;

`include "grid_min_entry_budget_dp_core_macros.svh"

  // ---------------------------------------------------------------
  // handshake and pipeline control
  // ---------------------------------------------------------------
  logic      in_acc;
  logic      s1_adv;
  cell_pos_t cur_pos;

  // compute stage: holds a cell while its below budget comes out of memory
  logic                s1_valid_q;
  cell_pos_t           s1_pos_q;
  logic [VAL_W-1:0]    s1_val_q;
  logic                s1_fwd_q;

  // output register
  logic                out_valid_q;
  logic [BUDGET_W-1:0] need_q;
  logic                answer_q;
  logic                sat_q;

  // running state of the recurrence
  logic [BUDGET_W-1:0] right_budget_q;
  logic [BUDGET_W-1:0] prev_need_q;
  logic                sticky_q;

  logic [BUDGET_W-1:0] rd_data;
  logic [BUDGET_W-1:0] below;
  logic [BUDGET_W-1:0] need;
  logic                clip;
  logic                grid_done;

  // stage leaves when the output register is empty or being drained
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------
  // position tracking and size registers
  // ---------------------------------------------------------------
  gmeb_pos_ctrl u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (in_acc),
    .pos_o       (cur_pos)
  );

  // ---------------------------------------------------------------
  // row buffer: read at accept, written back as the cell retires
  // ---------------------------------------------------------------
  gmeb_row_mem u_row_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (cur_pos.col),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_pos_q.col),
    .wr_data_i (need)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // same column read and written on one edge (single-column grid):
  // the memory returns stale data, so take the retiring budget instead
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pos_q <= cur_pos;
      s1_val_q <= cell_value_i;
      s1_fwd_q <= s1_valid_q && (s1_pos_q.col == cur_pos.col);
    end
  end

  assign below = s1_fwd_q ? prev_need_q : rd_data;

  // ---------------------------------------------------------------
  // cell arithmetic
  // ---------------------------------------------------------------
  gmeb_cell_calc u_calc (
    .pos_i        (s1_pos_q),
    .below_i      (below),
    .right_i      (right_budget_q),
    .cell_value_i (s1_val_q),
    .need_o       (need),
    .clip_o       (clip)
  );

  assign grid_done = s1_pos_q.last_col && s1_pos_q.last_row;

  // right neighbour and sticky clip flag, reset at the end of each grid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_budget_q <= BUDGET_ONE;
      sticky_q       <= 1'b0;
    end else if (s1_adv) begin
      right_budget_q <= grid_done ? BUDGET_ONE : need;
      sticky_q       <= grid_done ? 1'b0 : (sticky_q || clip);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      prev_need_q <= need;
    end
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      need_q   <= need;
      answer_q <= grid_done;
      sat_q    <= sticky_q || clip;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign need_budget_o = need_q;
  assign is_answer_o   = answer_q;
  assign saturated_o   = sat_q;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  `GMEB_ASSERT_SAME(a_need_nonzero, clk_i, rst_ni, out_valid_o, need_budget_o != '0)
  `GMEB_ASSERT_NEXT(a_right_reset, clk_i, rst_ni, s1_adv && grid_done, right_budget_q == BUDGET_ONE)
  `GMEB_ASSERT_NEXT(a_sticky_clear, clk_i, rst_ni, s1_adv && grid_done, !sticky_q)
  `GMEB_ASSERT_NEXT(a_clip_flag, clk_i, rst_ni, s1_adv && clip, out_valid_o && saturated_o)
  `GMEB_ASSERT_NEXT(a_clip_value, clk_i, rst_ni, s1_adv && clip, need_budget_o == BUDGET_MAX)
  `GMEB_ASSERT_SAME(a_no_overrun, clk_i, rst_ni, in_acc, !s1_valid_q || s1_adv)

endmodule
